// ----- rtl/line_and_command_splitter_defines.svh -----
// Assertion macros shared by the splitter RTL.
`ifndef LINE_AND_COMMAND_SPLITTER_DEFINES_SVH
`define LINE_AND_COMMAND_SPLITTER_DEFINES_SVH

// Clocked implication checked outside reset.
`define LCS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Clocked next-cycle implication checked outside reset.
`define LCS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/lcs_pkg.sv -----
// Constants and types of the line and command splitter.
package lcs_pkg;

    // Sizes
    localparam int DISPLAY_WIDTH = 10;
    localparam int COMMAND_DEPTH = 32;
    localparam int LINE_DEPTH    = 64;

    localparam int CMD_CNT_W  = $clog2(COMMAND_DEPTH);
    localparam int LINE_CNT_W = $clog2(LINE_DEPTH);
    localparam int DISP_IDX_W = (DISPLAY_WIDTH > 1) ? $clog2(DISPLAY_WIDTH) : 1;
    localparam int EMIT_MAX   = (DISPLAY_WIDTH > COMMAND_DEPTH - 1) ?
                                DISPLAY_WIDTH : COMMAND_DEPTH - 1;
    localparam int EMIT_W     = $clog2(EMIT_MAX + 1);

    // Characters
    localparam logic [7:0] CH_CR       = 8'd13;
    localparam logic [7:0] CH_LF       = 8'd10;
    localparam logic [7:0] CH_SPACE    = 8'd32;
    localparam logic [7:0] START_RESET = 8'd94;

    // Register map (byte address bit 2 selects the word)
    localparam logic REG_START_CHAR = 1'b0;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_LINE  = 2'd0,
        KIND_CMD   = 2'd1,
        KIND_EMPTY = 2'd2
    } kind_t;

endpackage

// ----- rtl/line_and_command_splitter.sv -----
// Top level of the line and command splitter.
//
// Received bytes arrive one per transfer on s_ and are accepted while the block is idle.
// A CR or LF ends the current item: a command then streams out its kept bytes (up to 31)
// or one empty-command marker, and a non-empty text line streams out ten display
// characters padded with spaces; an empty text line produces nothing. Results leave
// through an output register at one per cycle while m_tready stays high, walked by the
// single emit counter over the command and line stores. s_tready is low during emission.
// The start character is written over APB at byte address 0 (reset 0x5E).
module line_and_command_splitter (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_char
    output logic [1:0]  m_tuser,   // [1:0] result_kind
    output logic        m_tlast,   // last_of_run
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    `include "line_and_command_splitter_defines.svh"

    localparam int CW = lcs_pkg::CMD_CNT_W;
    localparam int LW = lcs_pkg::LINE_CNT_W;
    localparam int DW = lcs_pkg::DISP_IDX_W;
    localparam int EW = lcs_pkg::EMIT_W;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } state_t;

    state_t          state_reg, state_next;
    logic [7:0]      start_char_reg;
    logic            cmd_mode_reg, cmd_mode_next;
    logic [CW-1:0]   cmd_count_reg, cmd_count_next;
    logic [LW-1:0]   line_count_reg, line_count_next;
    logic [EW-1:0]   idx_reg, idx_next;
    logic [EW-1:0]   total_reg, total_next;
    logic [EW-1:0]   line_len_reg, line_len_next;
    lcs_pkg::kind_t  kind_reg, kind_next;
    logic            m_valid_reg, m_valid_next;
    logic [7:0]      m_char_reg, m_char_next;
    lcs_pkg::kind_t  m_kind_reg, m_kind_next;
    logic            m_last_reg, m_last_next;

    logic [7:0]      cmd_mem [lcs_pkg::COMMAND_DEPTH-1];
    logic [7:0]      line_mem [lcs_pkg::DISPLAY_WIDTH];
    logic [7:0]      cmd_rd_reg;
    logic [7:0]      line_rd_reg;

    logic            in_fire;
    logic            is_end;
    logic            is_start;
    logic            cmd_wr;
    logic            line_wr;
    logic            cfg_wr;
    logic            emit_fire;
    logic            emit_last;
    logic [7:0]      emit_char;

    assign pready   = 1'b1;
    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign is_end   = (s_tdata == lcs_pkg::CH_CR) || (s_tdata == lcs_pkg::CH_LF);
    assign is_start = !is_end && (s_tdata == start_char_reg);
    assign cfg_wr   = psel && penable && pwrite && pready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_char_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

    // Read back the start character
    assign prdata = (paddr[2] == lcs_pkg::REG_START_CHAR) ? {24'd0, start_char_reg} : 32'd0;

    // Store plain bytes while there is room
    assign cmd_wr  = in_fire && !is_end && !is_start && cmd_mode_reg &&
                     (cmd_count_reg < CW'(lcs_pkg::COMMAND_DEPTH - 1));
    assign line_wr = in_fire && !is_end && !is_start && !cmd_mode_reg &&
                     (line_count_reg < LW'(lcs_pkg::LINE_DEPTH - 1)) &&
                     ({1'b0, line_count_reg} < (LW + 1)'(lcs_pkg::DISPLAY_WIDTH));

    // Pick the character for the current emit index
    assign emit_last = (idx_reg == total_reg - EW'(1));
    assign emit_fire = (state_reg == ST_EMIT) && (!m_valid_reg || m_tready);

    always_comb begin
        case (kind_reg)
            lcs_pkg::KIND_CMD:  emit_char = cmd_rd_reg;
            lcs_pkg::KIND_LINE: emit_char = (idx_reg < line_len_reg) ? line_rd_reg
                                                                      : lcs_pkg::CH_SPACE;
            default:            emit_char = 8'd0;
        endcase
    end

    // Sequencer: collect bytes, then walk the stores on a line end
    always_comb begin
        state_next      = state_reg;
        cmd_mode_next   = cmd_mode_reg;
        cmd_count_next  = cmd_count_reg;
        line_count_next = line_count_reg;
        idx_next        = idx_reg;
        total_next      = total_reg;
        line_len_next   = line_len_reg;
        kind_next       = kind_reg;
        m_valid_next    = m_valid_reg;
        m_char_next     = m_char_reg;
        m_kind_next     = m_kind_reg;
        m_last_next     = m_last_reg;

        // Drop the output once it is taken
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                idx_next = '0;
                if (in_fire) begin
                    if (is_end) begin
                        if (cmd_mode_reg) begin
                            state_next = ST_EMIT;
                            if (cmd_count_reg == '0) begin
                                kind_next  = lcs_pkg::KIND_EMPTY;
                                total_next = EW'(1);
                            end else begin
                                kind_next  = lcs_pkg::KIND_CMD;
                                total_next = EW'(cmd_count_reg);
                            end
                        end else if (line_count_reg != '0) begin
                            state_next = ST_EMIT;
                            kind_next  = lcs_pkg::KIND_LINE;
                            total_next = EW'(lcs_pkg::DISPLAY_WIDTH);
                            if ({1'b0, line_count_reg} >=
                                (LW + 1)'(lcs_pkg::DISPLAY_WIDTH)) begin
                                line_len_next = EW'(lcs_pkg::DISPLAY_WIDTH);
                            end else begin
                                line_len_next = EW'(line_count_reg);
                            end
                        end
                        cmd_mode_next   = 1'b0;
                        cmd_count_next  = '0;
                        line_count_next = '0;
                    end else if (is_start) begin
                        cmd_mode_next   = 1'b1;
                        cmd_count_next  = '0;
                        line_count_next = '0;
                    end else if (cmd_mode_reg) begin
                        if (cmd_wr) begin
                            cmd_count_next = cmd_count_reg + CW'(1);
                        end
                    end else if (line_count_reg < LW'(lcs_pkg::LINE_DEPTH - 1)) begin
                        line_count_next = line_count_reg + LW'(1);
                    end
                end
            end
            ST_EMIT: begin
                if (emit_fire) begin
                    m_valid_next = 1'b1;
                    m_char_next  = emit_char;
                    m_kind_next  = kind_reg;
                    m_last_next  = emit_last;
                    if (emit_last) begin
                        state_next = ST_IDLE;
                        idx_next   = '0;
                    end else begin
                        idx_next = idx_reg + EW'(1);
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            start_char_reg <= lcs_pkg::START_RESET;
            cmd_mode_reg   <= 1'b0;
            cmd_count_reg  <= '0;
            line_count_reg <= '0;
            idx_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cmd_mode_reg   <= cmd_mode_next;
            cmd_count_reg  <= cmd_count_next;
            line_count_reg <= line_count_next;
            idx_reg        <= idx_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_wr && (paddr[2] == lcs_pkg::REG_START_CHAR)) begin
                start_char_reg <= pwdata[7:0];
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        total_reg    <= total_next;
        line_len_reg <= line_len_next;
        kind_reg     <= kind_next;
        m_char_reg   <= m_char_next;
        m_kind_reg   <= m_kind_next;
        m_last_reg   <= m_last_next;
    end

    // Stores: write at the fill count, read ahead at the next emit index
    always_ff @(posedge aclk) begin
        if (cmd_wr) begin
            cmd_mem[cmd_count_reg] <= s_tdata;
        end
        cmd_rd_reg <= cmd_mem[idx_next[CW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (line_wr) begin
            line_mem[DW'(line_count_reg)] <= s_tdata;
        end
        line_rd_reg <= line_mem[idx_next[DW-1:0]];
    end

    // Checks
    `LCS_ASSERT_IMPL(a_emit_in_range, state_reg == ST_EMIT, idx_reg < total_reg,
                     "emit index past run length")
    `LCS_ASSERT_IMPL(a_empty_single, state_reg == ST_EMIT && kind_reg == lcs_pkg::KIND_EMPTY,
                     total_reg == EW'(1), "empty command run longer than one result")
    `LCS_ASSERT_NEXT(a_last_ends_run, emit_fire && emit_last,
                     state_reg == ST_IDLE && m_valid_reg && m_last_reg,
                     "run did not end on its last result")
    `LCS_ASSERT_IMPL(a_no_store_in_emit, state_reg == ST_EMIT, !cmd_wr && !line_wr,
                     "store written during emission")

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench of the line and command splitter: drives bytes, checks results.
`timescale 1ns / 1ps

module testbench;

    localparam int QUIET_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 40;
    localparam int LONG_HOLD = 300;

    // Idle patterns: sender 27 / receiver 57, then swapped, then none
    localparam int IDLE_SLOW_OUT = 0;
    localparam int IDLE_SLOW_IN  = 1;
    localparam int IDLE_NONE     = 2;

    typedef struct {
        lcs_pkg::kind_t kind;
        logic [7:0]     ch;
        logic           last;
    } split_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;    // [7:0] rx_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;           // [7:0] out_char
    logic [1:0]  m_tuser;           // [1:0] result_kind
    logic        m_tlast;           // last_of_run
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    // Bytes waiting to be sent and results still to arrive
    logic [7:0]    rx_bytes[$];
    split_result_t pending_output[$];

    // Predicted splitter state
    logic [7:0] start_char = lcs_pkg::START_RESET;
    logic       in_command = 1'b0;
    logic [4:0] cmd_len = '0;
    logic [7:0] cmd_bytes [lcs_pkg::COMMAND_DEPTH-1];
    logic [5:0] line_len = '0;
    logic [7:0] line_bytes [lcs_pkg::DISPLAY_WIDTH];

    int idle_pattern = IDLE_SLOW_OUT;
    bit pressure_on = 1'b0;
    bit pressure_started = 1'b0;
    int hold_left = 0;
    int quiet_cycles = 0;
    int fail_count = 0;
    int bytes_sent = 0;
    int results_checked = 0;
    int commands_out = 0;
    int empties_out = 0;
    int lines_out = 0;

    line_and_command_splitter uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Advance the predicted state by one received byte and queue what it emits
    function automatic void split_rx_byte(input logic [7:0] rx);
        int i;
        if (rx == lcs_pkg::CH_CR || rx == lcs_pkg::CH_LF) begin
            if (in_command) begin
                if (cmd_len == 0) begin
                    pending_output.push_back(
                        split_result_t'{lcs_pkg::KIND_EMPTY, 8'h00, 1'b1});
                    empties_out++;
                end else begin
                    for (i = 0; i < cmd_len; i++)
                        pending_output.push_back(
                            split_result_t'{lcs_pkg::KIND_CMD, cmd_bytes[i], i + 1 == cmd_len});
                    commands_out++;
                end
                in_command = 1'b0;
                cmd_len = '0;
            end else if (line_len != 0) begin
                for (i = 0; i < lcs_pkg::DISPLAY_WIDTH; i++)
                    pending_output.push_back(split_result_t'{lcs_pkg::KIND_LINE,
                        (i < line_len) ? line_bytes[i] : lcs_pkg::CH_SPACE,
                        i + 1 == lcs_pkg::DISPLAY_WIDTH});
                lines_out++;
            end
            line_len = '0;
        end else if (rx == start_char) begin
            in_command = 1'b1;
            cmd_len = '0;
            line_len = '0;
        end else if (in_command) begin
            if (cmd_len < lcs_pkg::COMMAND_DEPTH - 1) begin
                cmd_bytes[cmd_len] = rx;
                cmd_len++;
            end
        end else if (line_len < lcs_pkg::LINE_DEPTH - 1) begin
            if (line_len < lcs_pkg::DISPLAY_WIDTH)
                line_bytes[line_len] = rx;
            line_len++;
        end
    endfunction

    function automatic bit sender_idles();
        int pct;
        pct = (idle_pattern == IDLE_SLOW_OUT) ? 27 : (idle_pattern == IDLE_SLOW_IN) ? 57 : 0;
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic bit receiver_idles();
        int pct;
        pct = (idle_pattern == IDLE_SLOW_OUT) ? 57 : (idle_pattern == IDLE_SLOW_IN) ? 27 : 0;
        return $urandom_range(0, 99) < pct;
    endfunction

    // Drive rx bytes from the queue; predict on each accepted transfer
    always @(posedge aclk) begin : drive_rx
        logic       next_valid;
        logic [7:0] next_data;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata <= 8'd0;
        end else begin
            next_valid = s_tvalid;
            next_data = s_tdata;
            if (s_tvalid && s_tready) begin
                split_rx_byte(s_tdata);
                bytes_sent++;
                next_valid = 1'b0;
            end
            if (!next_valid && rx_bytes.size() > 0 && !sender_idles()) begin
                next_valid = 1'b1;
                next_data = rx_bytes.pop_front();
            end
            s_tvalid <= next_valid;
            s_tdata <= next_data;
        end
    end

    // Check each result transfer against the oldest prediction; drive m_tready
    always @(posedge aclk) begin : check_results
        split_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_checked++;
                if (pending_output.size() == 0) begin
                    $error("unexpected result: kind %0d char %0h last %0b",
                           m_tuser, m_tdata, m_tlast);
                    fail_count++;
                end else begin
                    want = pending_output.pop_front();
                    if (m_tuser !== want.kind) begin
                        $error("result_kind: expected %0d, actual %0d", want.kind, m_tuser);
                        fail_count++;
                    end
                    if (m_tdata !== want.ch) begin
                        $error("out_char: expected %0h, actual %0h", want.ch, m_tdata);
                        fail_count++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last_of_run: expected %0b, actual %0b", want.last, m_tlast);
                        fail_count++;
                    end
                end
            end
            // Hold off once for a long stretch so the block backs up its input
            if (pressure_on && !pressure_started) begin
                pressure_started = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= !receiver_idles();
            end
        end
    end

    // End the run when nothing moves for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: %0d results still expected, %0d bytes unsent",
                     pending_output.size(), rx_bytes.size());
            $display("tb: failure");
            $finish;
        end
    end

    task automatic write_start_char(input logic [7:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {lcs_pkg::REG_START_CHAR, 2'b00};
        pwdata <= {24'd0, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        start_char = value;
    endtask

    // Wait for all bytes sent and all results seen, then let the block settle
    task automatic wait_drained();
        @(negedge aclk);
        while (rx_bytes.size() > 0 || s_tvalid || pending_output.size() > 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // Any byte that is neither a line end nor the start char
    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        while (b == lcs_pkg::CH_CR || b == lcs_pkg::CH_LF || b == start_char)
            b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    function automatic logic [7:0] line_end();
        return $urandom_range(0, 1) ? lcs_pkg::CH_CR : lcs_pkg::CH_LF;
    endfunction

    // Mostly well-formed commands and lines with random content, some noise
    task automatic queue_random_traffic(input int target);
        int queued;
        int pick;
        int len;
        int i;
        queued = 0;
        while (queued < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(28, 40) : $urandom_range(0, 8);
                rx_bytes.push_back(start_char);
                for (i = 0; i < len; i++)
                    rx_bytes.push_back(text_byte());
                rx_bytes.push_back(line_end());
                queued += len + 2;
            end else if (pick < 85) begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 70) : $urandom_range(0, 12);
                for (i = 0; i < len; i++)
                    rx_bytes.push_back(text_byte());
                // Some lines are cut off by a start char
                rx_bytes.push_back(($urandom_range(0, 9) == 0) ? start_char : line_end());
                queued += len + 1;
            end else begin
                rx_bytes.push_back(8'($urandom_range(0, 255)));
                queued++;
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty line, empty commands, restart, line cut by start, extreme bytes
        @(negedge aclk);
        idle_pattern = IDLE_SLOW_OUT;
        rx_bytes = '{lcs_pkg::CH_CR, lcs_pkg::CH_LF,
                     lcs_pkg::START_RESET, lcs_pkg::CH_CR,
                     lcs_pkg::START_RESET, lcs_pkg::CH_LF,
                     lcs_pkg::START_RESET, 8'h41, 8'h42, lcs_pkg::START_RESET, 8'h43,
                     lcs_pkg::CH_LF,
                     8'h00, 8'hFF, lcs_pkg::CH_CR,
                     8'h58, 8'h59, lcs_pkg::START_RESET, 8'h5A, lcs_pkg::CH_CR};
        wait_drained();

        write_start_char(8'h00);
        @(negedge aclk);
        idle_pattern = IDLE_SLOW_OUT;
        queue_random_traffic(90);
        wait_drained();

        write_start_char(8'hFF);
        @(negedge aclk);
        idle_pattern = IDLE_SLOW_IN;
        queue_random_traffic(90);
        wait_drained();

        // Start char equal to CR acts as a line end
        write_start_char(lcs_pkg::CH_CR);
        @(negedge aclk);
        idle_pattern = IDLE_NONE;
        queue_random_traffic(40);
        wait_drained();

        write_start_char(lcs_pkg::START_RESET);
        @(negedge aclk);
        idle_pattern = IDLE_NONE;
        pressure_on = 1'b1;
        queue_random_traffic(80);
        wait_drained();

        $display("tb: %0d bytes sent, %0d results checked (%0d commands, %0d empty, %0d lines)",
                 bytes_sent, results_checked, commands_out, empties_out, lines_out);
        $display("tb: start chars 94, 0, 255, CR, 94; three idle patterns and one long stall");
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
